[rtl/core/qmix_pkg.sv]
// shared types, constants and codes for the quad x motor mixer
package qmix_pkg;

	localparam int PWM_W       = 14;
	localparam int UNARM_W     = 16;
	localparam int LOOP_W      = 8;
	localparam int SILENCE_W   = 17;
	localparam int THR_W       = 7;
	localparam int CORR_W      = 13;
	localparam int MOTOR_W     = 17;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	localparam int SPAN_W      = PWM_W + 1;
	localparam int PROD_W      = SPAN_W + THR_W + 1;
	localparam int MAG_W       = PROD_W - 2;
	localparam int QUOT_W      = 15;
	localparam int MIX_W       = 18;
	localparam int DESAT_W     = MIX_W + 1;
	localparam int SUM_W       = MIX_W + 2;

	// truncating divide by 100 as multiply and shift, exact for magnitudes below 2^21
	localparam int PERCENT_FULL = 100;
	localparam int DIV_SHIFT    = 28;
	localparam int RECIP_W      = 22;
	localparam logic [RECIP_W-1:0] DIV_RECIP =
		RECIP_W'(((64'd1 << DIV_SHIFT) + PERCENT_FULL - 1) / PERCENT_FULL);

	localparam int QUEUE_DEPTH = 2;

	localparam logic [PWM_W-1:0]   PWM_MIN_RST   = PWM_W'(1000);
	localparam logic [PWM_W-1:0]   PWM_MAX_RST   = PWM_W'(2000);
	localparam logic [UNARM_W-1:0] DISARM_MS_RST = UNARM_W'(1000);
	localparam logic [LOOP_W-1:0]  TICK_MS_RST   = LOOP_W'(10);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PWM_MIN   = 2'd0,
		CFG_PWM_MAX   = 2'd1,
		CFG_DISARM_MS = 2'd2,
		CFG_TICK_MS   = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		REQ_TICK  = 2'd0,
		REQ_INPUT = 2'd1,
		REQ_MODE  = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		MODE_UNARMED = 2'd0,
		MODE_RATE    = 2'd1,
		MODE_ANGLE   = 2'd2
	} mode_t;

	localparam logic [1:0] MREQ_UNARM = 2'd0;
	localparam logic [1:0] MREQ_RATE  = 2'd1;
	localparam logic [1:0] MREQ_ANGLE = 2'd2;

	typedef struct packed {
		logic                     mix;
		logic [THR_W-1:0]         throttle;
		logic signed [CORR_W-1:0] correction_axis0;
		logic signed [CORR_W-1:0] correction_axis1;
		logic signed [CORR_W-1:0] correction_axis2;
		mode_t                    mode;
		logic                     timed_out;
	} qmix_entry_t;

	typedef struct packed {
		logic  mix;
		mode_t mode;
		logic  timed_out;
	} qmix_tag_t;

	typedef struct packed {
		logic [PWM_W-1:0] pwm_min;
		logic [PWM_W-1:0] pwm_max;
	} qmix_limits_t;

endpackage

[rtl/core/qmix_front.sv]
// front end: arming state, silence counter and classification of each transaction
module qmix_front import qmix_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               req_type,
	input  logic [THR_W-1:0]         throttle,
	input  logic signed [CORR_W-1:0] correction_axis0,
	input  logic signed [CORR_W-1:0] correction_axis1,
	input  logic signed [CORR_W-1:0] correction_axis2,
	input  logic [1:0]               mode_request,
	input  logic [UNARM_W-1:0]       disarm_ms,
	input  logic [LOOP_W-1:0]        tick_ms,
	output logic                     push,
	input  logic                     push_ready,
	output qmix_entry_t              push_entry
);

	mode_t                flight_mode_q;
	mode_t                mode_d;
	logic [SILENCE_W-1:0] silence_q;
	logic [SILENCE_W-1:0] silence_d;
	logic [SILENCE_W-1:0] silence_inc;
	logic                 tout;

	assign in_ready = push_ready;
	assign push     = in_valid && push_ready;

	assign silence_inc = silence_q + SILENCE_W'(tick_ms);

	always_comb begin
		mode_d    = flight_mode_q;
		silence_d = silence_q;
		tout      = 1'b0;
		unique case (req_type)
			REQ_TICK: begin
				silence_d = silence_inc;
				if (silence_inc > SILENCE_W'(disarm_ms)) begin
					mode_d    = MODE_UNARMED;
					silence_d = '0;
					tout      = 1'b1;
				end
			end
			REQ_INPUT: begin
				silence_d = '0;
			end
			REQ_MODE: begin
				unique case (mode_request)
					MREQ_UNARM: mode_d = MODE_UNARMED;
					MREQ_RATE:  mode_d = MODE_RATE;
					MREQ_ANGLE: mode_d = MODE_ANGLE;
					default:    mode_d = flight_mode_q;
				endcase
			end
			default: begin
				mode_d = flight_mode_q;
			end
		endcase
	end

	always_comb begin
		push_entry.mix              = (req_type == REQ_TICK) && (flight_mode_q != MODE_UNARMED);
		push_entry.throttle         = throttle;
		push_entry.correction_axis0 = correction_axis0;
		push_entry.correction_axis1 = correction_axis1;
		push_entry.correction_axis2 = correction_axis2;
		push_entry.mode             = mode_d;
		push_entry.timed_out        = tout;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flight_mode_q <= MODE_UNARMED;
			silence_q     <= '0;
		end else if (push) begin
			flight_mode_q <= mode_d;
			silence_q     <= silence_d;
		end
	end

endmodule

[rtl/core/qmix_fifo.sv]
// short queue of classified transactions between front end and mixer
module qmix_fifo import qmix_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        push_ready,
	input  qmix_entry_t push_entry,
	input  logic        pop,
	output logic        pop_valid,
	output qmix_entry_t pop_entry
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	qmix_entry_t       mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_entry  = mem_q[rd_ptr_q];
	assign do_pop     = pop && pop_valid;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		ptr_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/core/qmix_back.sv]
// back end: throttle scaling, quad x mix, desaturation shift and output register
module qmix_back import qmix_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  qmix_limits_t              limits,
	input  logic                      pop_valid,
	output logic                      pop,
	input  qmix_entry_t               pop_entry,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [MOTOR_W-1:0] motor_front_right,
	output logic signed [MOTOR_W-1:0] motor_front_left,
	output logic signed [MOTOR_W-1:0] motor_back_right,
	output logic signed [MOTOR_W-1:0] motor_back_left,
	output logic                      motors_valid,
	output logic [1:0]                current_mode,
	output logic                      timed_out
);

	logic advance;

	// stage 1: throttle times span
	logic                     v_s1;
	qmix_entry_t              ent_s1;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [SPAN_W-1:0] span;
	logic signed [PROD_W-1:0] prod;

	// stage 2: divide by 100
	logic                       v_s2;
	qmix_entry_t                ent_s2;
	logic signed [QUOT_W:0]     quot_s2;
	logic [MAG_W-1:0]           mag;
	logic [MAG_W+RECIP_W-1:0]   scaled;
	logic [QUOT_W-1:0]          qmag;

	// stage 3: base and mix
	logic                    v_s3;
	qmix_tag_t               tag_s3;
	logic signed [MIX_W-1:0] m_s3 [4];
	logic signed [MIX_W-1:0] base;
	logic signed [MIX_W-1:0] c0, c1, c2;

	// stage 4: overshoot and undershoot
	logic                      v_s4;
	qmix_tag_t                 tag_s4;
	logic signed [MIX_W-1:0]   m_s4 [4];
	logic signed [DESAT_W-1:0] up_s4;
	logic signed [DESAT_W-1:0] dn_s4;
	logic signed [DESAT_W-1:0] up;
	logic signed [DESAT_W-1:0] dn;
	logic signed [DESAT_W-1:0] hi_ext;
	logic signed [DESAT_W-1:0] lo_ext;

	// output register
	logic                      out_valid_q;
	logic signed [MOTOR_W-1:0] motor_q [4];
	logic                      motors_valid_q;
	mode_t                     mode_q;
	logic                      tout_q;
	logic signed [SUM_W-1:0]   shifted [4];

	assign advance = !out_valid_q || out_ready;
	assign pop     = advance && pop_valid;

	assign span = $signed({1'b0, limits.pwm_max}) - $signed({1'b0, limits.pwm_min});
	assign prod = $signed({1'b0, pop_entry.throttle}) * span;

	assign mag    = prod_s1[PROD_W-1] ? MAG_W'(-prod_s1) : MAG_W'(prod_s1);
	assign scaled = {{RECIP_W{1'b0}}, mag} * {{MAG_W{1'b0}}, DIV_RECIP};
	assign qmag   = scaled[DIV_SHIFT +: QUOT_W];

	assign base = $signed({{(MIX_W-PWM_W){1'b0}}, limits.pwm_min}) + MIX_W'(quot_s2);
	assign c0   = MIX_W'(ent_s2.correction_axis0);
	assign c1   = MIX_W'(ent_s2.correction_axis1);
	assign c2   = MIX_W'(ent_s2.correction_axis2);

	assign hi_ext = $signed({{(DESAT_W-PWM_W){1'b0}}, limits.pwm_max});
	assign lo_ext = $signed({{(DESAT_W-PWM_W){1'b0}}, limits.pwm_min});

	always_comb begin
		up = '0;
		dn = '0;
		for (int i = 0; i < 4; i++) begin
			if (DESAT_W'(m_s3[i]) - hi_ext > up) begin
				up = DESAT_W'(m_s3[i]) - hi_ext;
			end
			if (lo_ext - DESAT_W'(m_s3[i]) > dn) begin
				dn = lo_ext - DESAT_W'(m_s3[i]);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			shifted[i] = SUM_W'(m_s4[i]) - SUM_W'(up_s4) + SUM_W'(dn_s4);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			v_s1        <= pop_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			out_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ent_s1  <= pop_entry;
			prod_s1 <= prod;

			ent_s2  <= ent_s1;
			quot_s2 <= prod_s1[PROD_W-1] ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});

			tag_s3  <= '{mix: ent_s2.mix, mode: ent_s2.mode, timed_out: ent_s2.timed_out};
			m_s3[0] <= base - c0 - c1 + c2;
			m_s3[1] <= base + c0 - c1 - c2;
			m_s3[2] <= base - c0 + c1 - c2;
			m_s3[3] <= base + c0 + c1 + c2;

			tag_s4 <= tag_s3;
			m_s4   <= m_s3;
			up_s4  <= up;
			dn_s4  <= dn;

			for (int i = 0; i < 4; i++) begin
				motor_q[i] <= tag_s4.mix ? MOTOR_W'(shifted[i]) : '0;
			end
			motors_valid_q <= tag_s4.mix;
			mode_q         <= tag_s4.mode;
			tout_q         <= tag_s4.timed_out;
		end
	end

	assign out_valid         = out_valid_q;
	assign motor_front_right = motor_q[0];
	assign motor_front_left  = motor_q[1];
	assign motor_back_right  = motor_q[2];
	assign motor_back_left   = motor_q[3];
	assign motors_valid      = motors_valid_q;
	assign current_mode      = mode_q;
	assign timed_out         = tout_q;

endmodule

[rtl/core/quad_mixer_with_arming_failsafe.sv]
// top level of the quad x motor mixer with arming modes and input-silence failsafe
//
// three valid/ready channels: cfg (register index and data), in (one request per
// transaction) and out (one result per request, in order).
// request types: loop tick (mix when armed, grow the silence counter, unarm past
// the disarm limit), input received (clear the counter) and mode request.
// the front end updates mode and silence counter in the cycle a request is taken
// and queues it; the mixer behind the queue is a five-register pipeline
// (span product, divide by 100, mix, desaturation limits, output register).
// throughput: one transaction per cycle while out_ready stays high.
// when the receiver stalls, the pipeline holds and the queue of QUEUE_DEPTH entries
// fills, after which in_ready drops; nothing is lost or repeated.
// reset: unarmed, silence counter zero, registers at their reset values, pipeline
// and queue empty. cfg_ready is always high; registers are to be written only while
// nothing is in flight.
module quad_mixer_with_arming_failsafe import qmix_pkg::*; #(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [1:0]                req_type,
	input  logic [THR_W-1:0]          throttle,
	input  logic signed [CORR_W-1:0]  correction_axis0,
	input  logic signed [CORR_W-1:0]  correction_axis1,
	input  logic signed [CORR_W-1:0]  correction_axis2,
	input  logic [1:0]                mode_request,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [MOTOR_W-1:0] motor_front_right,
	output logic signed [MOTOR_W-1:0] motor_front_left,
	output logic signed [MOTOR_W-1:0] motor_back_right,
	output logic signed [MOTOR_W-1:0] motor_back_left,
	output logic                      motors_valid,
	output logic [1:0]                current_mode,
	output logic                      timed_out
);

	logic [PWM_W-1:0]   pwm_min_q;
	logic [PWM_W-1:0]   pwm_max_q;
	logic [UNARM_W-1:0] disarm_ms_q;
	logic [LOOP_W-1:0]  tick_ms_q;

	logic         push;
	logic         push_ready;
	qmix_entry_t  push_entry;
	logic         pop;
	logic         pop_valid;
	qmix_entry_t  pop_entry;
	qmix_limits_t limits;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_min_q   <= PWM_MIN_RST;
			pwm_max_q   <= PWM_MAX_RST;
			disarm_ms_q <= DISARM_MS_RST;
			tick_ms_q   <= TICK_MS_RST;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_PWM_MIN:   pwm_min_q   <= cfg_data[PWM_W-1:0];
				CFG_PWM_MAX:   pwm_max_q   <= cfg_data[PWM_W-1:0];
				CFG_DISARM_MS: disarm_ms_q <= cfg_data[UNARM_W-1:0];
				CFG_TICK_MS:   tick_ms_q   <= cfg_data[LOOP_W-1:0];
				default:       pwm_min_q   <= pwm_min_q;
			endcase
		end
	end

	assign limits = '{pwm_min: pwm_min_q, pwm_max: pwm_max_q};

	qmix_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.req_type         (req_type),
		.throttle         (throttle),
		.correction_axis0 (correction_axis0),
		.correction_axis1 (correction_axis1),
		.correction_axis2 (correction_axis2),
		.mode_request     (mode_request),
		.disarm_ms        (disarm_ms_q),
		.tick_ms          (tick_ms_q),
		.push             (push),
		.push_ready       (push_ready),
		.push_entry       (push_entry)
	);

	qmix_fifo #(
		.DEPTH (QDEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop        (pop),
		.pop_valid  (pop_valid),
		.pop_entry  (pop_entry)
	);

	qmix_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.limits            (limits),
		.pop_valid         (pop_valid),
		.pop               (pop),
		.pop_entry         (pop_entry),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.motor_front_right (motor_front_right),
		.motor_front_left  (motor_front_left),
		.motor_back_right  (motor_back_right),
		.motor_back_left   (motor_back_left),
		.motors_valid      (motors_valid),
		.current_mode      (current_mode),
		.timed_out         (timed_out)
	);

endmodule
